FILE: hw/rtl/twm_pkg.sv
// Package for the triangle warp metrics block: payload structs, widths, CORDIC table.
// Stand-alone; imported by triangle_warp_metrics_top.
`timescale 1ns / 1ps
package twm_pkg;

  localparam int COORD_W   = 32;
  localparam int NRM_W     = 18;
  localparam int TILT_W    = 18;
  localparam int ANG_FRAC  = 16;
  localparam int INT_FRAC  = 30;
  localparam int ANG_SHIFT = INT_FRAC - ANG_FRAC;

  localparam int EDGE_W = COORD_W + 1;
  localparam int XP_W   = 2 * EDGE_W;
  localparam int CR_W   = XP_W + 1;
  localparam int LEN1_W = $clog2(CR_W + 1);
  localparam int CUT    = 30;
  localparam int CC_W   = CUT + 1;
  localparam int NP_W   = CC_W + NRM_W;
  localparam int W_W    = NP_W + 1;
  localparam int D_W    = NP_W + 2;
  localparam int LEN2_W = $clog2(D_W + 1);
  localparam int SQR_W  = 2 * CUT;
  localparam int ROOT_W = 64;
  localparam int SQ_STEPS = ROOT_W / 2;
  localparam int CORDIC_ITERS = 31;
  localparam int CD_W   = 36;

  localparam int ASUM_W  = COORD_W + 2;
  localparam int ASUM_LO = ASUM_W / 2;
  localparam int DIV3_SH = ASUM_W + 1;
  localparam logic [ASUM_W-1:0] DIV3_M = ASUM_W'((64'd1 << DIV3_SH) / 3 + 64'd1);
  localparam int DP_W = ASUM_W + ASUM_W - ASUM_LO;

  localparam logic signed [NRM_W-1:0] NORM_LIMIT = NRM_W'(65536);

  localparam logic signed [CD_W-1:0] PI_Q30      = CD_W'(64'd3373259426);
  localparam logic signed [CD_W-1:0] HALF_PI_Q30 = CD_W'(64'd1686629713);
  localparam logic [TILT_W-1:0] HALF_PI_TILT =
    TILT_W'((64'd1686629713 + (64'd1 << (ANG_SHIFT - 1))) >> ANG_SHIFT);

  localparam logic signed [CD_W-1:0] ATAN_Q30 [CORDIC_ITERS] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64,
    32, 16, 8, 4, 2, 1
  };

  // Pipeline stage numbers (register stage that holds each result)
  localparam int ST_DIV  = 4;
  localparam int ST_DEG  = 5;
  localparam int ST_ZERO = 10;
  localparam int ST_CPRE = 13 + SQ_STEPS + 1;
  localparam int ST_OUT  = ST_CPRE + CORDIC_ITERS + 1;

  typedef enum logic [1:0] {
    CFG_NRM_X = 2'd0,
    CFG_NRM_Y = 2'd1,
    CFG_NRM_Z = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] v0_x;
    logic signed [COORD_W-1:0] v0_y;
    logic signed [COORD_W-1:0] v0_z;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_z;
  } tri_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] mean_abs_offset;
    logic [TILT_W-1:0]  tilt_angle;
    logic [COORD_W-1:0] offset_spread;
    logic               degenerate;
  } tri_out_t;

  typedef struct packed {
    logic [COORD_W-1:0] mean;
    logic [COORD_W-1:0] spread;
  } side_t;

endpackage

FILE: hw/rtl/triangle_warp_metrics_top.sv
// Triangle warp metrics: mean |z|, z spread and tilt angle against a reference normal.
// Depends on twm_pkg (widths, payload structs, CORDIC angle table).
`timescale 1ns / 1ps
//
// Usage:
//   Input channel: drive in_item with one triangle and pulse start. busy is always low,
//   so an item is taken at every edge where start is high, one per clock if desired.
//   Result channel: out_valid is high for one cycle with out_item; the receiver
//   cannot stall, so the pipeline never stops.
//   Config channel: cfg_valid/cfg_ready with cfg_index 0..2 selecting the reference
//   normal x, y, z (18 bit, saturated to +-1.0 on use). Index 3 is ignored. cfg_ready
//   is always high. Write only while no item is in flight.
// Pipeline: throughput one item per cycle.
//   The depth is set by the 32-step square root and the 31-step CORDIC, one step
//   per register stage.
// Reset: synchronous, active low. Clears the valid line and loads the reference normal
//   with (0, 0, 1.0). Items in flight are dropped.
// Degenerate triangles (zero cross product) report pi/2 with the degenerate flag.
//
module triangle_warp_metrics_top
  import twm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tri_in_t             in_item,
  output logic                out_valid,
  output tri_out_t            out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [NRM_W-1:0]    cfg_data
);

  // ---------------- helpers ----------------
  function automatic logic signed [NRM_W-1:0] sat_nrm(input logic signed [NRM_W-1:0] v);
    logic signed [NRM_W-1:0] r;
    r = v;
    if (v > NORM_LIMIT) r = NORM_LIMIT;
    else if (v < -NORM_LIMIT) r = -NORM_LIMIT;
    return r;
  endfunction

  // ---------------- configuration ----------------
  logic signed [NRM_W-1:0] nrm_x_r, nrm_y_r, nrm_z_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_x_r <= '0;
      nrm_y_r <= '0;
      nrm_z_r <= NORM_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NRM_X: nrm_x_r <= cfg_data;
        CFG_NRM_Y: nrm_y_r <= cfg_data;
        CFG_NRM_Z: nrm_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- valid line ----------------
  logic vld_r [1:ST_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= ST_OUT; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[1] <= start & ~busy;
      for (int k = 2; k <= ST_OUT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // ---------------- side path: mean |z| and spread ----------------
  logic [COORD_W-1:0]        az_r [3];
  logic signed [COORD_W-1:0] zmax_r, zmin_r;
  logic [ASUM_W-1:0]         asum_r;
  logic [COORD_W-1:0]        spread2_r, spread3_r;
  logic [DP_W-1:0]           plo_r, phi_r;
  side_t                     ms_r [ST_DIV:ST_OUT-1];

  logic signed [COORD_W-1:0] zmax_nxt, zmin_nxt;
  logic [DP_W+ASUM_LO-1:0]   dprod;

  always_comb begin
    zmax_nxt = in_item.v0_z;
    zmin_nxt = in_item.v0_z;
    if (in_item.v1_z > zmax_nxt) zmax_nxt = in_item.v1_z;
    if (in_item.v1_z < zmin_nxt) zmin_nxt = in_item.v1_z;
    if (in_item.v2_z > zmax_nxt) zmax_nxt = in_item.v2_z;
    if (in_item.v2_z < zmin_nxt) zmin_nxt = in_item.v2_z;
    dprod = {phi_r, {ASUM_LO{1'b0}}} + (DP_W + ASUM_LO)'(plo_r);
  end

  always_ff @(posedge clk) begin
    az_r[0] <= in_item.v0_z[COORD_W-1] ? COORD_W'(-in_item.v0_z) : in_item.v0_z;
    az_r[1] <= in_item.v1_z[COORD_W-1] ? COORD_W'(-in_item.v1_z) : in_item.v1_z;
    az_r[2] <= in_item.v2_z[COORD_W-1] ? COORD_W'(-in_item.v2_z) : in_item.v2_z;
    zmax_r  <= zmax_nxt;
    zmin_r  <= zmin_nxt;
    asum_r    <= ASUM_W'(az_r[0]) + ASUM_W'(az_r[1]) + ASUM_W'(az_r[2]);
    spread2_r <= COORD_W'(zmax_r - zmin_r);
    // divide by three: reciprocal multiply in two halves
    plo_r     <= DP_W'(asum_r[ASUM_LO-1:0]) * DP_W'(DIV3_M);
    phi_r     <= DP_W'(asum_r[ASUM_W-1:ASUM_LO]) * DP_W'(DIV3_M);
    spread3_r <= spread2_r;
    ms_r[ST_DIV].mean   <= dprod[DIV3_SH +: COORD_W];
    ms_r[ST_DIV].spread <= spread3_r;
    for (int k = ST_DIV + 1; k <= ST_OUT - 1; k++) ms_r[k] <= ms_r[k-1];
  end

  // ---------------- tilt: cross product and first cut ----------------
  logic signed [EDGE_W-1:0] e_r [3];
  logic signed [EDGE_W-1:0] f_r [3];
  logic signed [XP_W-1:0]   pr_r [6];
  logic signed [CR_W-1:0]   cw_r [3];
  logic [CR_W-1:0]          mag4_r [3];
  logic                     sgn4_r [3];
  logic [CR_W-1:0]          or4_r;
  logic [CR_W-1:0]          mag5_r [3];
  logic                     sgn5_r [3];
  logic [LEN1_W-1:0]        sh5_r;
  logic                     dg_r [ST_DEG:ST_OUT-1];
  logic signed [CC_W-1:0]   c6_r [3];

  logic [LEN1_W-1:0]        len1;
  logic [CC_W-1:0]          ct [3];

  always_comb begin
    len1 = '0;
    for (int i = 0; i < CR_W; i++)
      if (or4_r[i]) len1 = LEN1_W'(i + 1);
    for (int k = 0; k < 3; k++) begin
      ct[k] = CC_W'(mag5_r[k] >> sh5_r);
      if (sgn5_r[k]) ct[k] = CC_W'(-ct[k]);
    end
  end

  always_ff @(posedge clk) begin
    e_r[0] <= EDGE_W'(in_item.v1_x) - EDGE_W'(in_item.v0_x);
    e_r[1] <= EDGE_W'(in_item.v1_y) - EDGE_W'(in_item.v0_y);
    e_r[2] <= EDGE_W'(in_item.v1_z) - EDGE_W'(in_item.v0_z);
    f_r[0] <= EDGE_W'(in_item.v2_x) - EDGE_W'(in_item.v0_x);
    f_r[1] <= EDGE_W'(in_item.v2_y) - EDGE_W'(in_item.v0_y);
    f_r[2] <= EDGE_W'(in_item.v2_z) - EDGE_W'(in_item.v0_z);
    pr_r[0] <= XP_W'(e_r[1]) * XP_W'(f_r[2]);
    pr_r[1] <= XP_W'(e_r[2]) * XP_W'(f_r[1]);
    pr_r[2] <= XP_W'(e_r[2]) * XP_W'(f_r[0]);
    pr_r[3] <= XP_W'(e_r[0]) * XP_W'(f_r[2]);
    pr_r[4] <= XP_W'(e_r[0]) * XP_W'(f_r[1]);
    pr_r[5] <= XP_W'(e_r[1]) * XP_W'(f_r[0]);
    for (int k = 0; k < 3; k++) begin
      cw_r[k]   <= CR_W'(pr_r[2*k]) - CR_W'(pr_r[2*k+1]);
      sgn4_r[k] <= cw_r[k][CR_W-1];
      mag4_r[k] <= cw_r[k][CR_W-1] ? CR_W'(-cw_r[k]) : CR_W'(cw_r[k]);
      mag5_r[k] <= mag4_r[k];
      sgn5_r[k] <= sgn4_r[k];
      c6_r[k]   <= ct[k];
    end
    // OR of magnitudes has the bit length of the largest one
    or4_r <= (cw_r[0][CR_W-1] ? CR_W'(-cw_r[0]) : CR_W'(cw_r[0]))
           | (cw_r[1][CR_W-1] ? CR_W'(-cw_r[1]) : CR_W'(cw_r[1]))
           | (cw_r[2][CR_W-1] ? CR_W'(-cw_r[2]) : CR_W'(cw_r[2]));
    sh5_r <= (len1 > LEN1_W'(CUT)) ? LEN1_W'(len1 - LEN1_W'(CUT)) : '0;
    dg_r[ST_DEG] <= (or4_r == '0);
    for (int k = ST_DEG + 1; k <= ST_OUT - 1; k++) dg_r[k] <= dg_r[k-1];
  end

  // ---------------- tilt: w = c x n, d = c.n, second cut ----------------
  logic signed [NP_W-1:0] pw_r [9];
  logic signed [W_W-1:0]  w_r [3];
  logic signed [D_W-1:0]  d_r;
  logic [W_W-1:0]         wm9_r [3];
  logic [D_W-1:0]         dm9_r;
  logic                   dneg9_r;
  logic [D_W-1:0]         or9_r;
  logic [W_W-1:0]         wm10_r [3];
  logic [D_W-1:0]         dm10_r;
  logic                   dneg10_r;
  logic [LEN2_W-1:0]      sh10_r;
  logic                   zr_r [ST_ZERO:ST_OUT-1];
  logic [CUT-1:0]         v11_r [3];
  logic [CUT-1:0]         dv11_r;
  logic                   dneg11_r;
  logic [SQR_W-1:0]       sqr_r [3];
  logic [CUT-1:0]         dv12_r;
  logic                   dneg12_r;

  logic signed [NRM_W-1:0] nx, ny, nz;
  logic [LEN2_W-1:0]       len2;
  logic [W_W-1:0]          wm_nxt [3];

  always_comb begin
    nx = sat_nrm(nrm_x_r);
    ny = sat_nrm(nrm_y_r);
    nz = sat_nrm(nrm_z_r);
    len2 = '0;
    for (int i = 0; i < D_W; i++)
      if (or9_r[i]) len2 = LEN2_W'(i + 1);
    for (int k = 0; k < 3; k++)
      wm_nxt[k] = w_r[k][W_W-1] ? W_W'(-w_r[k]) : W_W'(w_r[k]);
  end

  always_ff @(posedge clk) begin
    pw_r[0] <= NP_W'(c6_r[1]) * NP_W'(nz);
    pw_r[1] <= NP_W'(c6_r[2]) * NP_W'(ny);
    pw_r[2] <= NP_W'(c6_r[2]) * NP_W'(nx);
    pw_r[3] <= NP_W'(c6_r[0]) * NP_W'(nz);
    pw_r[4] <= NP_W'(c6_r[0]) * NP_W'(ny);
    pw_r[5] <= NP_W'(c6_r[1]) * NP_W'(nx);
    pw_r[6] <= NP_W'(c6_r[0]) * NP_W'(nx);
    pw_r[7] <= NP_W'(c6_r[1]) * NP_W'(ny);
    pw_r[8] <= NP_W'(c6_r[2]) * NP_W'(nz);
    for (int k = 0; k < 3; k++) w_r[k] <= W_W'(pw_r[2*k]) - W_W'(pw_r[2*k+1]);
    d_r <= D_W'(pw_r[6]) + D_W'(pw_r[7]) + D_W'(pw_r[8]);
    for (int k = 0; k < 3; k++) begin
      wm9_r[k]  <= wm_nxt[k];
      wm10_r[k] <= wm9_r[k];
      v11_r[k]  <= CUT'(wm10_r[k] >> sh10_r);
      sqr_r[k]  <= SQR_W'(v11_r[k]) * SQR_W'(v11_r[k]);
    end
    dneg9_r <= d_r[D_W-1];
    dm9_r   <= d_r[D_W-1] ? D_W'(-d_r) : D_W'(d_r);
    or9_r   <= D_W'(wm_nxt[0]) | D_W'(wm_nxt[1]) | D_W'(wm_nxt[2])
             | (d_r[D_W-1] ? D_W'(-d_r) : D_W'(d_r));
    dm10_r   <= dm9_r;
    dneg10_r <= dneg9_r;
    sh10_r   <= (len2 > LEN2_W'(CUT)) ? LEN2_W'(len2 - LEN2_W'(CUT)) : '0;
    zr_r[ST_ZERO] <= (or9_r == '0);
    for (int k = ST_ZERO + 1; k <= ST_OUT - 1; k++) zr_r[k] <= zr_r[k-1];
    dv11_r   <= CUT'(dm10_r >> sh10_r);
    dneg11_r <= dneg10_r;
    dv12_r   <= dv11_r;
    dneg12_r <= dneg11_r;
  end

  // ---------------- square root of |w|^2, one result bit per stage ----------------
  logic [ROOT_W-1:0]      sq_rem_r  [0:SQ_STEPS];
  logic [ROOT_W-1:0]      sq_root_r [0:SQ_STEPS];
  logic signed [CC_W-1:0] xd_r      [0:SQ_STEPS];

  logic [ROOT_W-1:0] sq_rem_nxt  [SQ_STEPS];
  logic [ROOT_W-1:0] sq_root_nxt [SQ_STEPS];

  always_comb begin
    logic [ROOT_W-1:0] bitv;
    logic [ROOT_W-1:0] trial;
    for (int k = 0; k < SQ_STEPS; k++) begin
      bitv  = ROOT_W'(1) << (2 * (SQ_STEPS - 1 - k));
      trial = sq_root_r[k] + bitv;
      if (sq_rem_r[k] >= trial) begin
        sq_rem_nxt[k]  = sq_rem_r[k] - trial;
        sq_root_nxt[k] = (sq_root_r[k] >> 1) + bitv;
      end else begin
        sq_rem_nxt[k]  = sq_rem_r[k];
        sq_root_nxt[k] = sq_root_r[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_rem_r[0]  <= ROOT_W'(sqr_r[0]) + ROOT_W'(sqr_r[1]) + ROOT_W'(sqr_r[2]);
    sq_root_r[0] <= '0;
    xd_r[0]      <= dneg12_r ? CC_W'(-CC_W'(dv12_r)) : CC_W'(dv12_r);
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_rem_r[k+1]  <= sq_rem_nxt[k];
      sq_root_r[k+1] <= sq_root_nxt[k];
      xd_r[k+1]      <= xd_r[k];
    end
  end

  // ---------------- vectoring CORDIC, one iteration per stage ----------------
  logic signed [CD_W-1:0] cx_r [0:CORDIC_ITERS];
  logic signed [CD_W-1:0] cy_r [0:CORDIC_ITERS];
  logic signed [CD_W-1:0] cz_r [0:CORDIC_ITERS];

  logic signed [CD_W-1:0] x0, y0;
  logic signed [CD_W-1:0] cx_nxt [CORDIC_ITERS];
  logic signed [CD_W-1:0] cy_nxt [CORDIC_ITERS];
  logic signed [CD_W-1:0] cz_nxt [CORDIC_ITERS];

  always_comb begin
    logic signed [CD_W-1:0] xs;
    logic signed [CD_W-1:0] ys;
    x0 = CD_W'(xd_r[SQ_STEPS]);
    y0 = CD_W'(sq_root_r[SQ_STEPS]);
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = cx_r[i] >>> i;
      ys = cy_r[i] >>> i;
      if (cy_r[i] > 0) begin
        cx_nxt[i] = cx_r[i] + ys;
        cy_nxt[i] = cy_r[i] - xs;
        cz_nxt[i] = cz_r[i] + ATAN_Q30[i];
      end else begin
        cx_nxt[i] = cx_r[i] - ys;
        cy_nxt[i] = cy_r[i] + xs;
        cz_nxt[i] = cz_r[i] - ATAN_Q30[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    // rotate a left-half vector by -90 degrees first
    if (x0 < 0) begin
      cx_r[0] <= y0;
      cy_r[0] <= -x0;
      cz_r[0] <= HALF_PI_Q30;
    end else begin
      cx_r[0] <= x0;
      cy_r[0] <= y0;
      cz_r[0] <= '0;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      cx_r[i+1] <= cx_nxt[i];
      cy_r[i+1] <= cy_nxt[i];
      cz_r[i+1] <= cz_nxt[i];
    end
  end

  // ---------------- output register ----------------
  logic signed [CD_W-1:0] zc;
  logic [CD_W-1:0]        zrnd;
  tri_out_t               out_item_r;

  always_comb begin
    zc = cz_r[CORDIC_ITERS];
    if (zc < 0) zc = '0;
    else if (zc > PI_Q30) zc = PI_Q30;
    zrnd = CD_W'(zc) + (CD_W'(1) << (ANG_SHIFT - 1));
  end

  always_ff @(posedge clk) begin
    out_item_r.mean_abs_offset <= ms_r[ST_OUT-1].mean;
    out_item_r.offset_spread   <= ms_r[ST_OUT-1].spread;
    out_item_r.degenerate      <= dg_r[ST_OUT-1];
    out_item_r.tilt_angle      <= (dg_r[ST_OUT-1] || zr_r[ST_OUT-1]) ? HALF_PI_TILT
                                  : zrnd[ANG_SHIFT +: TILT_W];
  end

  assign out_valid = vld_r[ST_OUT];
  assign out_item  = out_item_r;

endmodule

FILE: bench/twm_checker.sv
// Scoreboard for triangle_warp_metrics_top: watches the item, result and register ports,
// predicts each result and compares it against the block. Depends on twm_pkg.
`timescale 1ns / 1ps
module twm_checker
  import twm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  tri_in_t          in_item,
  input  logic             out_valid,
  input  tri_out_t         out_item,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [NRM_W-1:0] cfg_data,
  output int               mismatches,
  output int               pending
);

  logic [NRM_W-1:0] nrm_x, nrm_y, nrm_z;
  tri_out_t         metrics_due[$];

  function automatic logic signed [127:0] wide_mul(input longint a, input longint b);
    logic signed [127:0] wa = a;
    logic signed [127:0] wb = b;
    return wa * wb;
  endfunction

  function automatic longint clamp_nrm(input logic [NRM_W-1:0] r);
    longint v = longint'($signed(r));
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC, atan2(y, x) for y >= 0, Q2.30
  function automatic longint cordic_angle(input longint y, input longint x);
    longint z = 0;
    longint t, xs, ys;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = longint'(HALF_PI_Q30);
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
      end
    end
    return z;
  endfunction

  function automatic logic [TILT_W-1:0] round_angle(input longint z);
    longint unsigned u;
    if (z < 0) z = 0;
    if (z > longint'(PI_Q30)) z = longint'(PI_Q30);
    u = (longint'(z) + (64'd1 << (ANG_SHIFT - 1))) >> ANG_SHIFT;
    return u[TILT_W-1:0];
  endfunction

  function automatic tri_out_t warp_metrics(input tri_in_t t);
    longint v[9], e[3], f[3], c[3], n[3], w[3], d, zmax, zmin;
    longint unsigned abs_sum, wm[3], dm, m, sum, sh;
    logic signed [127:0] cw[3], mag[3];
    int len, s;
    tri_out_t r;
    v = '{t.v0_x, t.v0_y, t.v0_z, t.v1_x, t.v1_y, t.v1_z, t.v2_x, t.v2_y, t.v2_z};
    for (int k = 0; k < 3; k++) begin
      e[k] = v[3+k] - v[k];
      f[k] = v[6+k] - v[k];
    end
    zmax = v[2]; zmin = v[2]; abs_sum = 0;
    for (int k = 2; k <= 8; k += 3) begin
      if (v[k] > zmax) zmax = v[k];
      if (v[k] < zmin) zmin = v[k];
      abs_sum += (v[k] < 0) ? -v[k] : v[k];
    end
    abs_sum = abs_sum / 3;
    r.mean_abs_offset = abs_sum[31:0];
    sh = zmax - zmin;
    r.offset_spread = sh[31:0];
    r.degenerate = 1'b0;

    cw[0] = wide_mul(e[1], f[2]) - wide_mul(e[2], f[1]);
    cw[1] = wide_mul(e[2], f[0]) - wide_mul(e[0], f[2]);
    cw[2] = wide_mul(e[0], f[1]) - wide_mul(e[1], f[0]);
    len = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (cw[k] < 0) ? -cw[k] : cw[k];
      for (int i = 0; i < 128; i++) if (mag[k][i] && i + 1 > len) len = i + 1;
    end
    if (len == 0) begin
      r.degenerate = 1'b1;
      r.tilt_angle = round_angle(longint'(HALF_PI_Q30));
      return r;
    end
    // cut c to 30 bits of magnitude, truncating toward zero
    s = (len > CUT) ? len - CUT : 0;
    for (int k = 0; k < 3; k++) begin
      c[k] = longint'(mag[k] >> s);
      if (cw[k] < 0) c[k] = -c[k];
    end
    n[0] = clamp_nrm(nrm_x); n[1] = clamp_nrm(nrm_y); n[2] = clamp_nrm(nrm_z);
    w[0] = c[1] * n[2] - c[2] * n[1];
    w[1] = c[2] * n[0] - c[0] * n[2];
    w[2] = c[0] * n[1] - c[1] * n[0];
    d = c[0] * n[0] + c[1] * n[1] + c[2] * n[2];
    dm = (d < 0) ? -d : d;
    m = dm;
    for (int k = 0; k < 3; k++) begin
      wm[k] = (w[k] < 0) ? -w[k] : w[k];
      if (wm[k] > m) m = wm[k];
    end
    if (m == 0) begin
      r.tilt_angle = round_angle(longint'(HALF_PI_Q30));
      return r;
    end
    len = 0;
    for (int i = 0; i < 64; i++) if (m[i]) len = i + 1;
    s = (len > CUT) ? len - CUT : 0;
    sum = 0;
    for (int k = 0; k < 3; k++) sum += (wm[k] >> s) * (wm[k] >> s);
    dm >>= s;
    r.tilt_angle = round_angle(cordic_angle(longint'(root_floor(sum)),
                                            (d < 0) ? -longint'(dm) : longint'(dm)));
    return r;
  endfunction

  assign pending = metrics_due.size();

  always @(posedge clk) begin
    tri_out_t want;
    if (!rst_n) begin
      nrm_x <= '0;
      nrm_y <= '0;
      nrm_z <= NRM_W'(65536);
      metrics_due.delete();
      mismatches <= 0;
    end else begin
      if (out_valid) begin
        if (metrics_due.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %p", out_item);
          mismatches <= mismatches + 1;
        end else begin
          want = metrics_due.pop_front();
          if (want.mean_abs_offset !== out_item.mean_abs_offset ||
              want.tilt_angle !== out_item.tilt_angle ||
              want.offset_spread !== out_item.offset_spread ||
              want.degenerate !== out_item.degenerate) begin
            if (mismatches < 10)
              $display("mismatch: expected mean %0d tilt %0d spread %0d degen %0d, got %0d %0d %0d %0d",
                       want.mean_abs_offset, want.tilt_angle, want.offset_spread,
                       want.degenerate, out_item.mean_abs_offset, out_item.tilt_angle,
                       out_item.offset_spread, out_item.degenerate);
            mismatches <= mismatches + 1;
          end
        end
      end
      // queue the prediction for the accepted item at the tail
      if (start && !busy) metrics_due = {metrics_due, warp_metrics(in_item)};
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NRM_X: nrm_x <= cfg_data;
          CFG_NRM_Y: nrm_y <= cfg_data;
          CFG_NRM_Z: nrm_z <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: bench/tb_triangle_warp_metrics_top.sv
// Testbench top for triangle_warp_metrics_top: clock, reset, item and register stimulus.
// Depends on twm_pkg and twm_checker, which predicts and compares every result.
`timescale 1ns / 1ps
module tb_triangle_warp_metrics_top
  import twm_pkg::*;
();

  localparam logic [1:0] CFG_SPARE = 2'd3;  // unused index, write must be ignored
  localparam int CYCLE_LIMIT = 200000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  tri_in_t          in_item;
  logic             out_valid;
  tri_out_t         out_item;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [NRM_W-1:0] cfg_data;
  int               mismatches;
  int               pending;
  int               cycles;
  bit               gaps_on;

  triangle_warp_metrics_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  twm_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one triangle; idle at random first, hold until the block takes it.
  task automatic send_tri(input tri_in_t t);
    bit stalled;
    while (gaps_on && $urandom_range(99) < 38) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= t;
    do begin
      #4 stalled = busy;
      @(posedge clk);
    end while (stalled);
    @(negedge clk);
  endtask

  // Drop start and wait for every predicted result to come back.
  task automatic drain;
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [NRM_W-1:0] data);
    bit stalled;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      #4 stalled = !cfg_ready;
      @(posedge clk);
    end while (stalled);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_normal(input int x, input int y, input int z);
    drain();
    write_reg(CFG_NRM_X, NRM_W'(x));
    write_reg(CFG_NRM_Y, NRM_W'(y));
    write_reg(CFG_NRM_Z, NRM_W'(z));
  endtask

  function automatic tri_in_t make_tri(input int a0, input int a1, input int a2,
                                       input int b0, input int b1, input int b2,
                                       input int c0, input int c1, input int c2);
    tri_in_t t;
    t = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    return t;
  endfunction

  // Mix full-range, mesh-sized and collinear triangles.
  function automatic tri_in_t random_tri;
    tri_in_t t;
    int unsigned pick, k;
    pick = $urandom_range(99);
    t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom};
    if (pick < 45) begin
      // mesh-sized coordinates: shift right arithmetically, sign extend
      t.v0_x = $signed(t.v0_x) >>> 12; t.v0_y = $signed(t.v0_y) >>> 12;
      t.v1_x = $signed(t.v1_x) >>> 12; t.v1_y = $signed(t.v1_y) >>> 12;
      t.v2_x = $signed(t.v2_x) >>> 12; t.v2_y = $signed(t.v2_y) >>> 12;
      t.v0_z = $signed(t.v0_z) >>> $urandom_range(31);
      t.v1_z = $signed(t.v1_z) >>> $urandom_range(31);
      t.v2_z = $signed(t.v2_z) >>> $urandom_range(31);
    end else if (pick < 55) begin
      // collinear: third vertex on the line through the first two
      k = $urandom_range(3);
      t.v0_x = $signed(t.v0_x) >>> 4; t.v0_y = $signed(t.v0_y) >>> 4;
      t.v0_z = $signed(t.v0_z) >>> 4;
      t.v1_x = $signed(t.v1_x) >>> 4; t.v1_y = $signed(t.v1_y) >>> 4;
      t.v1_z = $signed(t.v1_z) >>> 4;
      t.v2_x = t.v0_x + k * (t.v1_x - t.v0_x);
      t.v2_y = t.v0_y + k * (t.v1_y - t.v0_y);
      t.v2_z = t.v0_z + k * (t.v1_z - t.v0_z);
    end
    return t;
  endfunction

  task automatic random_run(input int count);
    repeat (count) send_tri(random_tri());
  endtask

  initial begin
    int lo, hi;
    lo = 32'sh8000_0000;
    hi = 32'sh7fff_ffff;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NRM_X;
    cfg_data  = '0;
    cycles    = 0;
    gaps_on   = 1'b1;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed triangles under the reset normal (0, 0, 1)
    send_tri('0);                                             // all zero, degenerate
    send_tri(make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0));    // flat, angle zero
    send_tri(make_tri(0, 0, 0, 0, 65536, 0, 65536, 0, 0));    // flipped, angle pi
    send_tri(make_tri(0, 0, 0, 65536, 0, 0, 0, 0, 65536));    // upright, pi/2
    send_tri(make_tri(0, 0, lo, 1, 0, hi, 0, 1, 0));          // widest z spread
    send_tri(make_tri(lo, lo, lo, hi, lo, lo, lo, hi, lo));   // mean of most negative z
    send_tri(make_tri(hi, hi, hi, lo, hi, hi, hi, lo, hi));
    send_tri(make_tri(lo, hi, lo, hi, lo, hi, lo, lo, hi));
    send_tri(make_tri(hi, lo, hi, lo, hi, lo, hi, hi, lo));
    send_tri(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1));   // repeated vertex
    send_tri(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));            // collinear
    send_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));            // tiny cross product
    send_tri(make_tri(0, 0, 0, 65536, 0, 30000, 0, 65536, -30000));
    send_tri(make_tri(hi, 0, 0, 0, hi, 0, 0, 0, hi));
    send_tri(make_tri(lo, 0, 0, 0, lo, 0, 0, 0, lo));
    random_run(120);

    // Pause until every result is back, then run with no idling
    set_normal(0, 0, -65536);
    gaps_on = 1'b0;
    send_tri(make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
    random_run(130);
    gaps_on = 1'b1;

    set_normal(65536, 0, 0);
    random_run(110);

    // Out-of-range codes saturate; spare index must not disturb the normal
    set_normal(131071, -131072, 131071);
    write_reg(CFG_SPARE, NRM_W'(12345));
    random_run(110);

    // Zero normal: always pi/2
    set_normal(0, 0, 0);
    send_tri(make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
    random_run(60);

    set_normal(-65536, 65536, -65536);
    random_run(110);

    repeat (3) begin
      set_normal($urandom_range(131071) - 65536, $urandom_range(131071) - 65536,
                 $urandom_range(131071) - 65536);
      random_run(50);
    end

    drain();
    repeat (ST_OUT + 10) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
